// ----- hw/rtl/bfd_pkg.sv -----
// Package for the block RAM file device: shared widths, defaults,
// request codes and the control state type.
// No dependencies.
`default_nettype none
package bfd_pkg;

    // Fixed field widths of the request and response items
    localparam int CMD_W   = 2;
    localparam int BYTES_W = 4;
    localparam int DATA_W  = 64;

    // Byte position and byte total are 11-bit counters that wrap
    localparam int POS_W   = 11;

    // Default geometry of the file RAM
    localparam int WORD_BYTES_DEF = 8;
    localparam int WORDS_DEF      = 128;

    // Request kinds, echoed unchanged in the response
    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_WAIT
    } t_state;

endpackage
`default_nettype wire

// ----- hw/rtl/block_ram_file_device.sv -----
// Block RAM file device: one file held in a RAM of WORDS words of WORD_BYTES
// bytes. Each request item (open, write, read, close) gets exactly one
// response item. The RAM is accessed in the accept cycle at the word index of
// the current byte position; a read answer is ready in the cycle after. After
// every item the word index of the new position is worked out by two
// reciprocal dividers (by WORD_BYTES, then modulo WORDS), and the next item
// is taken only once that index is ready, so no new item is taken before the
// last one is through. Responses wait in an output register.
// Depends on bfd_pkg, bfd_ram and bfd_cdiv.
`default_nettype none
module block_ram_file_device #(
    parameter int WORD_BYTES = bfd_pkg::WORD_BYTES_DEF,
    parameter int WORDS      = bfd_pkg::WORDS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [bfd_pkg::CMD_W-1:0]    i_command,
    input  wire logic [bfd_pkg::BYTES_W-1:0]  i_byte_request,
    input  wire logic [bfd_pkg::DATA_W-1:0]   i_write_word,
    // response channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [bfd_pkg::CMD_W-1:0]    o_done_kind,
    output logic      [bfd_pkg::BYTES_W-1:0]  o_bytes_done,
    output logic      [bfd_pkg::DATA_W-1:0]   o_read_word
);

    localparam int POS_W  = bfd_pkg::POS_W;
    localparam int WORD_W = WORD_BYTES * 8;
    localparam int IDX_W  = $clog2(WORDS);
    localparam int CAP_W  = 17;
    localparam logic [CAP_W-1:0] CAPACITY = CAP_W'(WORD_BYTES * WORDS);

    bfd_pkg::t_state              r_state, n_state;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [POS_W-1:0]             r_total, n_total;
    logic [IDX_W-1:0]             r_widx;
    logic                         r_idx_ok;
    logic [bfd_pkg::CMD_W-1:0]    r_cmd;
    logic [bfd_pkg::BYTES_W-1:0]  r_done;
    logic                         r_rd_hit;
    logic                         r_out_valid;
    logic [bfd_pkg::CMD_W-1:0]    r_out_kind;
    logic [bfd_pkg::BYTES_W-1:0]  r_out_bytes;
    logic [bfd_pkg::DATA_W-1:0]   r_out_word;

    logic                         in_acc;
    logic                         out_free;
    logic                         load_out;
    logic                         has_room;
    logic                         not_eof;
    logic                         wr_ok;
    logic                         rd_ok;
    logic                         ram_we;
    logic                         ram_re;
    logic [WORD_W-1:0]            ram_rdata;
    logic [POS_W-1:0]             pos_add;
    logic                         da_done;
    logic [POS_W-1:0]             da_quot;
    logic                         db_done;
    logic [POS_W-1:0]             db_rem;
    logic [bfd_pkg::BYTES_W-1:0]  n_done;

    // Handshake
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Request decode against the current file state
    assign has_room = ({{(CAP_W-POS_W){1'b0}}, r_total} < CAPACITY);
    assign not_eof  = (r_pos < r_total);
    assign wr_ok    = (i_command == bfd_pkg::CMD_WRITE) && has_room;
    assign rd_ok    = (i_command == bfd_pkg::CMD_READ) && not_eof;
    assign ram_we   = in_acc && wr_ok && (i_byte_request != '0);
    assign ram_re   = in_acc && rd_ok;
    assign pos_add  = r_pos + POS_W'(i_byte_request);

    // Next position, total and byte count
    always_comb begin
        n_pos   = r_pos;
        n_total = r_total;
        n_done  = '0;
        case (bfd_pkg::t_cmd'(i_command))
            bfd_pkg::CMD_OPEN: begin
                n_pos = '0;
            end
            bfd_pkg::CMD_WRITE: begin
                if (has_room) begin
                    n_pos  = pos_add;
                    n_done = i_byte_request;
                    if (pos_add > r_total) begin
                        n_total = pos_add;
                    end
                end
            end
            bfd_pkg::CMD_READ: begin
                if (not_eof) begin
                    n_pos  = pos_add;
                    n_done = i_byte_request;
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    // File RAM
    bfd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_widx),
        .i_wdata (i_write_word[WORD_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Word index of the new position: divide by word size, then wrap
    bfd_cdiv #(
        .IN_W    (POS_W),
        .DIVISOR (WORD_BYTES)
    ) u_div_word (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_x     (n_pos),
        .o_done  (da_done),
        .o_quot  (da_quot),
        .o_rem   ()
    );

    bfd_cdiv #(
        .IN_W    (POS_W),
        .DIVISOR (WORDS)
    ) u_div_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (da_done),
        .i_x     (da_quot),
        .o_done  (db_done),
        .o_quot  (),
        .o_rem   (db_rem)
    );

    // Sequencer: respond, then wait for the new word index
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        load_out   = 1'b0;
        case (r_state)
            bfd_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = bfd_pkg::S_RESP;
                end
            end
            bfd_pkg::S_RESP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = bfd_pkg::S_WAIT;
                end
            end
            bfd_pkg::S_WAIT: begin
                if (r_idx_ok || db_done) begin
                    n_state = bfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfd_pkg::S_IDLE;
            r_pos       <= '0;
            r_total     <= '0;
            r_widx      <= '0;
            r_idx_ok    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_pos    <= n_pos;
                r_total  <= n_total;
                r_idx_ok <= 1'b0;
            end else if (db_done) begin
                r_idx_ok <= 1'b1;
            end
            if (db_done) begin
                r_widx <= IDX_W'(db_rem);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item held between accept and response
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_command;
            r_done   <= n_done;
            r_rd_hit <= rd_ok;
        end
        if (load_out) begin
            r_out_kind  <= r_cmd;
            r_out_bytes <= r_done;
            r_out_word  <= r_rd_hit ? bfd_pkg::DATA_W'(ram_rdata) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_done_kind  = r_out_kind;
    assign o_bytes_done = r_out_bytes;
    assign o_read_word  = r_out_word;

`ifndef ASSERT_OFF
    // An accepted item always closes the input side for the next cycle
    a_stall_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // The RAM is never written once the file is full
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> has_room)
        else $error("RAM write at capacity");

    // Open and close never report bytes or data
    a_open_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_done_kind == bfd_pkg::CMD_OPEN ||
                         o_done_kind == bfd_pkg::CMD_CLOSE))
        |-> (o_bytes_done == '0 && o_read_word == '0))
        else $error("open or close item reports bytes");

    // No item is taken before the word index of the position is ready
    a_index_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_idx_ok)
        else $error("item accepted with stale word index");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/bfd_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module bfd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read, read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hw/rtl/bfd_cdiv.sv -----
// Two-stage divide of an unsigned value by a fixed divisor: reciprocal
// multiply, then one compare-and-subtract correction. Depends on nothing.
`default_nettype none
module bfd_cdiv #(
    parameter int IN_W    = 11,
    parameter int DIVISOR = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [IN_W-1:0]   i_x,
    output logic                   o_done,
    output logic      [IN_W-1:0]   o_quot,
    output logic      [IN_W-1:0]   o_rem
);

    // floor(2^IN_W / DIVISOR); the estimate is low by at most one
    localparam int MULT_W = IN_W + 1;
    localparam int DIV_W  = $clog2(DIVISOR + 1) + 1;
    localparam int WIDE_W = IN_W + DIV_W;
    localparam logic [MULT_W-1:0] MULT = MULT_W'((2 ** IN_W) / DIVISOR);
    localparam logic [DIV_W-1:0]  DIVC = DIV_W'(DIVISOR);

    logic                     r_v1;
    logic                     r_v2;
    logic [IN_W-1:0]          r_x;
    logic [IN_W-1:0]          r_q0;
    logic [IN_W-1:0]          r_quot;
    logic [IN_W-1:0]          r_rem;
    logic [IN_W+MULT_W-1:0]   prod;
    logic [WIDE_W-1:0]        back;
    logic [WIDE_W-1:0]        diff;
    logic                     fix;

    // Stage 1: quotient estimate
    assign prod = (IN_W + MULT_W)'(i_x) * (IN_W + MULT_W)'(MULT);

    // Stage 2: remainder and correction
    assign back = WIDE_W'(r_q0) * WIDE_W'(DIVC);
    assign diff = WIDE_W'(r_x) - back;
    assign fix  = (diff >= WIDE_W'(DIVC));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x  <= i_x;
            r_q0 <= prod[IN_W +: IN_W];
        end
        if (r_v1) begin
            r_quot <= fix ? r_q0 + IN_W'(1) : r_q0;
            r_rem  <= fix ? IN_W'(diff - WIDE_W'(DIVC)) : IN_W'(diff);
        end
    end

    assign o_done = r_v2;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- bench/block_ram_file_device_tb.sv -----
// Self-checking testbench for block_ram_file_device: random and directed file requests
// are checked against a cycle-free prediction of the file state and stored words.
// Depends on bfd_pkg and the block_ram_file_device RTL.
`timescale 1ns / 1ps

module block_ram_file_device_tb;

    localparam int CLK_HALF_NS     = 6;
    localparam int FILE_WORD_BYTES = bfd_pkg::WORD_BYTES_DEF;
    localparam int FILE_WORDS      = bfd_pkg::WORDS_DEF;
    localparam int CAPACITY        = FILE_WORD_BYTES * FILE_WORDS;
    localparam logic [bfd_pkg::DATA_W-1:0] WORD_MASK =
        (FILE_WORD_BYTES >= 8) ? {bfd_pkg::DATA_W{1'b1}}
                               : ((64'd1 << (8 * FILE_WORD_BYTES)) - 64'd1);
    localparam int RANDOM_END      = 900;
    localparam int RX_HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RUN_LIMIT_NS    = 400_000 * 2 * CLK_HALF_NS;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [bfd_pkg::CMD_W-1:0]    i_command;
    logic [bfd_pkg::BYTES_W-1:0]  i_byte_request;
    logic [bfd_pkg::DATA_W-1:0]   i_write_word;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [bfd_pkg::CMD_W-1:0]    o_done_kind;
    logic [bfd_pkg::BYTES_W-1:0]  o_bytes_done;
    logic [bfd_pkg::DATA_W-1:0]   o_read_word;

    // pacing controls shared between stimulus and the response sink
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;
    int sent_count  = 0;

    // one response item as the file should answer it
    typedef struct {
        logic [bfd_pkg::CMD_W-1:0]   kind;
        logic [bfd_pkg::BYTES_W-1:0] nbytes;
        logic [bfd_pkg::DATA_W-1:0]  word;
    } t_file_answer;

    // Tracks the file: position, length and stored words, and the answers still owed
    class file_scoreboard;
        logic [bfd_pkg::DATA_W-1:0] words [FILE_WORDS];
        bit                         written [FILE_WORDS];
        logic [bfd_pkg::POS_W-1:0]  pos;
        logic [bfd_pkg::POS_W-1:0]  total;
        t_file_answer               answers_due [$];
        int                         errors;

        function new();
            pos    = '0;
            total  = '0;
            errors = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int word_slot();
            return (int'(pos) / FILE_WORD_BYTES) % FILE_WORDS;
        endfunction

        // a read touches the RAM only before end of file
        function bit read_is_safe();
            return (pos >= total) || written[word_slot()];
        endfunction

        function void note_request(bfd_pkg::t_cmd cmd, logic [bfd_pkg::BYTES_W-1:0] nb,
                                   logic [bfd_pkg::DATA_W-1:0] wd);
            t_file_answer ans;
            ans.kind   = cmd;
            ans.nbytes = '0;
            ans.word   = '0;
            case (cmd)
                bfd_pkg::CMD_OPEN: begin
                    pos = '0;
                end
                bfd_pkg::CMD_WRITE: begin
                    // full file: nothing stored, position untouched
                    if (total < CAPACITY) begin
                        if (nb != '0) begin
                            words[word_slot()]   = wd & WORD_MASK;
                            written[word_slot()] = 1'b1;
                        end
                        ans.nbytes = nb;
                        pos = pos + nb;
                        if (pos > total) total = pos;
                    end
                end
                bfd_pkg::CMD_READ: begin
                    if (pos < total) begin
                        ans.word   = words[word_slot()];
                        ans.nbytes = nb;
                        pos = pos + nb;
                    end
                end
                default: ;
            endcase
            answers_due.push_back(ans);
        endfunction

        function void check_response(logic [bfd_pkg::CMD_W-1:0] kind,
                                     logic [bfd_pkg::BYTES_W-1:0] nb,
                                     logic [bfd_pkg::DATA_W-1:0] word);
            t_file_answer ans;
            if (answers_due.size() == 0) begin
                $error("done_kind: no response outstanding, got %0d", kind);
                errors++;
                return;
            end
            ans = answers_due.pop_front();
            if (kind !== ans.kind) begin
                $error("done_kind: expected %0d, got %0d", ans.kind, kind);
                errors++;
            end
            if (nb !== ans.nbytes) begin
                $error("bytes_done: expected %0d, got %0d", ans.nbytes, nb);
                errors++;
            end
            if (word !== ans.word) begin
                $error("read_word: expected %h, got %h", ans.word, word);
                errors++;
            end
        endfunction
    endclass

    file_scoreboard sb = new();

    block_ram_file_device u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_byte_request (i_byte_request),
        .i_write_word   (i_write_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_done_kind    (o_done_kind),
        .o_bytes_done   (o_bytes_done),
        .o_read_word    (o_read_word)
    );

    // 12 ns clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // check every response item taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_response(o_done_kind, o_bytes_done, o_read_word);
    end

    // response sink: random stall per item, with one long hold on request
    initial begin : response_sink
        int gap;
        i_out_stall = 1'b1;
        forever begin
            if (rx_hold_req) begin
                gap = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                gap = rx_steady ? 0 : $urandom_range(0, 9);
            end
            repeat (gap) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_rst_n === 1'b1));
        end
    end

    // run limit
    initial begin
        #RUN_LIMIT_NS;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [bfd_pkg::DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly full words, sometimes any size the field allows
    function automatic logic [bfd_pkg::BYTES_W-1:0] pick_size();
        return ($urandom_range(0, 9) == 0) ? bfd_pkg::BYTES_W'($urandom_range(0, 15))
                                           : bfd_pkg::BYTES_W'(FILE_WORD_BYTES);
    endfunction

    // Offer one item and wait for it to be taken. A read that would hit a never
    // written word is turned into a full-word write.
    task automatic send_request(input bfd_pkg::t_cmd cmd,
                                input logic [bfd_pkg::BYTES_W-1:0] nb,
                                input logic [bfd_pkg::DATA_W-1:0] wd);
        int            gap;
        bfd_pkg::t_cmd c;
        c = cmd;
        if (c == bfd_pkg::CMD_READ && !sb.read_is_safe()) begin
            c  = bfd_pkg::CMD_WRITE;
            nb = bfd_pkg::BYTES_W'(FILE_WORD_BYTES);
        end
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_command      <= c;
        i_byte_request <= nb;
        i_write_word   <= wd;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(c, nb, wd);
        sent_count++;
    endtask

    // open, a run of writes and reads with random content, usually a close
    task automatic run_session();
        int ops;
        ops = $urandom_range(2, 16);
        send_request(bfd_pkg::CMD_OPEN, pick_size(), rand_word());
        repeat (ops) begin
            if ($urandom_range(0, 1) == 1)
                send_request(bfd_pkg::CMD_WRITE, pick_size(), rand_word());
            else
                send_request(bfd_pkg::CMD_READ, pick_size(), rand_word());
        end
        if ($urandom_range(0, 4) != 0)
            send_request(bfd_pkg::CMD_CLOSE, pick_size(), rand_word());
    endtask

    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = bfd_pkg::CMD_OPEN;
        i_byte_request = '0;
        i_write_word   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty file, extreme data, zero and odd sizes, unaligned reads
        send_request(bfd_pkg::CMD_CLOSE, 4'd0, '0);
        send_request(bfd_pkg::CMD_READ, 4'd8, '0);
        send_request(bfd_pkg::CMD_OPEN, 4'd15, {bfd_pkg::DATA_W{1'b1}});
        send_request(bfd_pkg::CMD_WRITE, 4'd8, {bfd_pkg::DATA_W{1'b1}});
        send_request(bfd_pkg::CMD_WRITE, 4'd8, '0);
        send_request(bfd_pkg::CMD_WRITE, 4'd8, 64'hA5A5_5A5A_C3C3_3C3C);
        send_request(bfd_pkg::CMD_WRITE, 4'd0, 64'h1234_5678_9ABC_DEF0);
        send_request(bfd_pkg::CMD_WRITE, 4'd15, 64'h5555_5555_5555_5555);
        send_request(bfd_pkg::CMD_WRITE, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(bfd_pkg::CMD_WRITE, 4'd1, 64'h8000_0000_0000_0001);
        send_request(bfd_pkg::CMD_OPEN, 4'd8, '0);
        send_request(bfd_pkg::CMD_READ, 4'd8, '0);
        send_request(bfd_pkg::CMD_READ, 4'd0, '0);
        send_request(bfd_pkg::CMD_READ, 4'd8, '0);
        send_request(bfd_pkg::CMD_READ, 4'd15, '0);
        send_request(bfd_pkg::CMD_READ, 4'd3, '0);
        send_request(bfd_pkg::CMD_READ, 4'd8, '0);
        send_request(bfd_pkg::CMD_READ, 4'd8, '0);
        send_request(bfd_pkg::CMD_READ, 4'd8, {bfd_pkg::DATA_W{1'b1}});
        send_request(bfd_pkg::CMD_CLOSE, 4'd15, {bfd_pkg::DATA_W{1'b1}});
        send_request(bfd_pkg::CMD_WRITE, 4'd8, 64'h0F0F_F0F0_0F0F_F0F0);

        // random sessions and noise
        while (sent_count < RANDOM_END) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if (!hold_done && sent_count >= 300) begin
                // long receiver hold while items keep coming
                hold_done   = 1'b1;
                tx_steady   = 1'b1;
                rx_hold_req = 1'b1;
            end
            if (!pause_done && sent_count >= 600) begin
                // stop offering, then wait until every answer is back
                pause_done = 1'b1;
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (sb.answers_due.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 7) begin
                run_session();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_request(bfd_pkg::t_cmd'($urandom_range(0, 3)),
                                 bfd_pkg::BYTES_W'($urandom_range(0, 15)), rand_word());
            end
        end

        // fill the whole file from the start; the last write runs past capacity
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_request(bfd_pkg::CMD_OPEN, 4'd8, rand_word());
        while (sb.total < CAPACITY)
            send_request(bfd_pkg::CMD_WRITE,
                         (sb.pos >= CAPACITY - FILE_WORD_BYTES)
                             ? 4'd15 : bfd_pkg::BYTES_W'(FILE_WORD_BYTES),
                         rand_word());
        repeat (3) send_request(bfd_pkg::CMD_WRITE, pick_size(), rand_word());

        // read it all back, wrapping the word address, then past end of file
        send_request(bfd_pkg::CMD_OPEN, 4'd0, rand_word());
        while (sb.pos < sb.total)
            send_request(bfd_pkg::CMD_READ, bfd_pkg::BYTES_W'(FILE_WORD_BYTES), rand_word());
        repeat (2) send_request(bfd_pkg::CMD_READ, pick_size(), rand_word());
        send_request(bfd_pkg::CMD_CLOSE, 4'd0, rand_word());

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.answers_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_ram.sv
hw/rtl/bfd_cdiv.sv
hw/rtl/block_ram_file_device.sv
bench/block_ram_file_device_tb.sv
